// ===== src/crc32ta_pkg.sv =====
`timescale 1ns / 1ps
// shared types, codes and the byte-wise crc-32 update for the trailer block
// no dependencies

package crc32ta_pkg;

	localparam logic [31:0] CRC_POLY = 32'hEDB88320;

	// configuration register indexes
	localparam logic CFG_MODE     = 1'b0;
	localparam logic CFG_CRC_INIT = 1'b1;

	// mode values
	localparam logic MODE_APPEND = 1'b0;
	localparam logic MODE_CHECK  = 1'b1;

	// check status codes
	localparam logic [1:0] ST_GOOD     = 2'd0;
	localparam logic [1:0] ST_MISMATCH = 2'd1;
	localparam logic [1:0] ST_SHORT    = 2'd2;

	// bytes_seen saturates at the trailer length
	localparam logic [2:0] BS_FULL = 3'd4;

	// result group sizes
	localparam logic [2:0] GRP_ONE  = 3'd1;
	localparam logic [2:0] GRP_FIVE = 3'd5;

	// all results caused by one input item
	typedef struct packed {
		logic [4:0][7:0] bytes;
		logic [2:0]      cnt;
		logic            first_valid;
		logic            last;
		logic [1:0]      status;
	} grp_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
		end
		return c;
	endfunction

endpackage

// ===== src/crc32ta_core.sv =====
`timescale 1ns / 1ps
// input register, crc state, trailer delay line and result group builder
// depends on crc32ta_pkg

module crc32ta_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [7:0]         data_byte,
	input  logic               last,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               mode,
	input  logic [31:0]        crc_initial,
	output crc32ta_pkg::grp_t  grp,
	output logic               push,
	input  logic               full
);
	import crc32ta_pkg::*;

	logic [7:0]      data_s1;
	logic            last_s1;
	logic            valid_s1;
	logic [31:0]     running_crc_q;
	logic [3:0][7:0] td_q;
	logic [2:0]      bs_q;

	logic            fire;
	logic            grp_push;
	logic [31:0]     crc_base;
	logic [31:0]     crc_nxt;
	logic [3:0][7:0] td_nxt;
	logic [2:0]      bs_nxt;

	assign in_stall = valid_s1 & full;
	assign fire     = valid_s1 & ~full;
	assign push     = fire & grp_push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= (in_valid & ~in_stall) | in_stall;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_s1 <= data_byte;
			last_s1 <= last;
		end
	end

	always_comb begin
		crc_base = (bs_q == 3'd0) ? crc_initial : running_crc_q;
		crc_nxt  = crc_base;
		td_nxt   = td_q;
		bs_nxt   = bs_q;
		grp      = '0;
		grp_push = 1'b0;
		if (mode == MODE_APPEND) begin
			crc_nxt          = crc_byte(crc_base, data_s1);
			grp.bytes[0]     = data_s1;
			grp.first_valid  = 1'b1;
			grp.cnt          = GRP_ONE;
			grp_push         = 1'b1;
			if (last_s1) begin
				grp.bytes[1] = crc_nxt[7:0];
				grp.bytes[2] = crc_nxt[15:8];
				grp.bytes[3] = crc_nxt[23:16];
				grp.bytes[4] = crc_nxt[31:24];
				grp.cnt      = GRP_FIVE;
				grp.last     = 1'b1;
				bs_nxt       = 3'd0;
			end else if (bs_q < BS_FULL) begin
				bs_nxt = bs_q + 3'd1;
			end
		end else begin
			if (bs_q >= BS_FULL) begin
				// oldest byte leaves and enters the crc
				crc_nxt         = crc_byte(crc_base, td_q[0]);
				td_nxt          = {data_s1, td_q[3:1]};
				grp.bytes[0]    = td_q[0];
				grp.first_valid = 1'b1;
				grp.cnt         = GRP_ONE;
				grp_push        = 1'b1;
			end else begin
				td_nxt[bs_q[1:0]] = data_s1;
				bs_nxt            = bs_q + 3'd1;
			end
			if (last_s1) begin
				// held trailer read little-endian straight off the packed line
				if (bs_nxt < BS_FULL) begin
					grp.status = ST_SHORT;
				end else if (td_nxt == crc_nxt) begin
					grp.status = ST_GOOD;
				end else begin
					grp.status = ST_MISMATCH;
				end
				grp.cnt  = GRP_ONE;
				grp.last = 1'b1;
				grp_push = 1'b1;
				bs_nxt   = 3'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_crc_q <= '0;
			td_q          <= '0;
			bs_q          <= '0;
		end else if (fire) begin
			running_crc_q <= crc_nxt;
			td_q          <= td_nxt;
			bs_q          <= bs_nxt;
		end
	end

endmodule

// ===== src/crc32ta_emit.sv =====
`timescale 1ns / 1ps
// two-entry result group queue and serializer onto the output channel
// depends on crc32ta_pkg

module crc32ta_emit (
	input  logic              clk,
	input  logic              arst_n,
	input  crc32ta_pkg::grp_t grp,
	input  logic              push,
	output logic              full,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        out_byte,
	output logic              byte_valid,
	output logic              out_last,
	output logic [1:0]        status
);
	import crc32ta_pkg::*;

	grp_t       q_mem [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic [2:0] sub_q;

	grp_t       head;
	logic       final_sub;
	logic       take;
	logic       pop;

	assign head      = q_mem[rd_ptr_q];
	assign full      = (count_q == 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign final_sub = (sub_q == head.cnt - 3'd1);
	assign take      = out_valid & ~out_stall;
	assign pop       = take & final_sub;

	assign out_byte   = head.bytes[sub_q];
	assign byte_valid = (sub_q == 3'd0) ? head.first_valid : 1'b1;
	assign out_last   = final_sub & head.last;
	assign status     = final_sub ? head.status : ST_GOOD;

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= grp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
			sub_q    <= 3'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
				sub_q    <= 3'd0;
			end else if (take) begin
				sub_q <= sub_q + 3'd1;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// ===== src/crc32_trailer_append_check.sv =====
`timescale 1ns / 1ps
// Reflected CRC-32 trailer append / check-and-strip for a byte stream. Each
// accepted item is one packet byte with a last mark; the crc (poly 0xEDB88320,
// lsb first, seeded from crc_initial at every packet start, no final xor) is
// updated one byte per cycle in a single register stage, so one item per cycle
// is accepted when the output side keeps up. In append mode (mode = 0) every
// byte gives one output item and the last byte gives four more carrying the
// crc, least significant byte first, the fourth with out_last set. In check
// mode (mode = 1) a four-byte delay line holds back the trailer; a payload
// byte leaves once four newer bytes have arrived. On the last byte the held
// trailer, read little-endian, is compared with the crc and dropped; status
// on the out_last item is good, mismatch, or too short (fewer than four bytes,
// nothing forwarded). When no payload byte leaves with the last byte, a single
// item with byte_valid low carries out_last and status. An accepted byte passes
// the input register and the byte stage before it is queued; a two-group output
// queue decouples in_stall from out_stall. Write configuration only while the
// block is idle.
// depends on crc32ta_pkg, crc32ta_core, crc32ta_emit

module crc32_trailer_append_check (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last,
	// output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        byte_valid,
	output logic        out_last,
	output logic [1:0]  status
);
	import crc32ta_pkg::*;

	logic        mode_q;
	logic [31:0] crc_init_q;

	grp_t        grp;
	logic        push;
	logic        full;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_APPEND;
			crc_init_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MODE:     mode_q     <= cfg_data[0];
				CFG_CRC_INIT: crc_init_q <= cfg_data;
				default:      ;
			endcase
		end
	end

	// byte stage: crc update, delay line, result group
	crc32ta_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.data_byte   (data_byte),
		.last        (last),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.mode        (mode_q),
		.crc_initial (crc_init_q),
		.grp         (grp),
		.push        (push),
		.full        (full)
	);

	// group queue and per-item serializer
	crc32ta_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.grp        (grp),
		.push       (push),
		.full       (full),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.byte_valid (byte_valid),
		.out_last   (out_last),
		.status     (status)
	);

	// a full queue always has something to offer
	a_full_has_output: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> out_valid)
		else $error("queue full without output");

	// status is only given on the final item of a packet
	a_status_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_last) |-> (status == ST_GOOD))
		else $error("status on non-final item");

	// an empty item only ever closes a packet
	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !byte_valid) |-> out_last)
		else $error("empty item that is not last");

	// no push into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("push into full queue");

endmodule

// ===== bench/crc32ta_stream_check.sv =====
`timescale 1ns / 1ps
// stream checker for crc32_trailer_append_check: watches the config port and both channels,
// predicts the output items of every accepted byte and compares them in order
// depends on crc32ta_pkg

module crc32ta_stream_check (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [7:0]  out_byte,
	input  logic        byte_valid,
	input  logic        out_last,
	input  logic [1:0]  status,
	output int          fail_count,
	output int          beats_left
);
	import crc32ta_pkg::*;

	localparam int PRINT_CAP = 200;

	typedef struct packed {
		logic [7:0] data;
		logic       valid;
		logic       fin;
		logic [1:0] code;
	} beat_t;

	beat_t      beats_due[$];
	logic       cfg_mode;
	logic [31:0] cfg_seed;
	logic [31:0] crc_acc;
	logic [7:0] delay_line [4];
	logic [2:0] seen;

	// one data bit per step, xor folded in at the lsb
	function automatic logic [31:0] crc_step(input logic [31:0] acc, input logic [7:0] d);
		logic [31:0] r;
		r = acc;
		for (int k = 0; k < 8; k++) begin
			if (r[0] ^ d[k])
				r = {1'b0, r[31:1]} ^ CRC_POLY;
			else
				r = {1'b0, r[31:1]};
		end
		return r;
	endfunction

	task automatic note_miss(input string what, input logic [31:0] got, input logic [31:0] want);
		if (fail_count < PRINT_CAP)
			$display("%0t ERROR %s: got %0h, want %0h", $time, what, got, want);
		fail_count++;
	endtask

	task automatic predict_beats(input logic [7:0] d, input logic fin);
		beat_t      nb;
		logic [1:0] code;
		logic [31:0] held;
		bit         leaving;
		leaving = 0;
		nb = '0;
		if (seen == 3'd0)
			crc_acc = cfg_seed;
		if (cfg_mode == MODE_APPEND) begin
			crc_acc = crc_step(crc_acc, d);
			nb.data = d;
			nb.valid = 1'b1;
			beats_due.push_back(nb);
			if (fin) begin
				for (int k = 0; k < 4; k++) begin
					nb.data = crc_acc[8*k +: 8];
					nb.fin = (k == 3);
					beats_due.push_back(nb);
				end
				seen = 3'd0;
			end else if (seen < BS_FULL) begin
				seen++;
			end
		end else begin
			// oldest held byte leaves once the line is full
			if (seen >= BS_FULL) begin
				nb.data = delay_line[0];
				nb.valid = 1'b1;
				crc_acc = crc_step(crc_acc, delay_line[0]);
				delay_line[0] = delay_line[1];
				delay_line[1] = delay_line[2];
				delay_line[2] = delay_line[3];
				delay_line[3] = d;
				leaving = 1;
			end else begin
				delay_line[seen[1:0]] = d;
				seen++;
			end
			if (fin) begin
				if (seen < BS_FULL) begin
					code = ST_SHORT;
				end else begin
					held = {delay_line[3], delay_line[2], delay_line[1], delay_line[0]};
					code = (held == crc_acc) ? ST_GOOD : ST_MISMATCH;
				end
				nb.fin = 1'b1;
				nb.code = code;
				seen = 3'd0;
			end
			if (leaving || fin)
				beats_due.push_back(nb);
		end
	endtask

	task automatic check_beat();
		beat_t want;
		if (beats_due.size() == 0) begin
			note_miss("item with nothing pending", {24'd0, out_byte}, 32'd0);
		end else begin
			want = beats_due.pop_front();
			if (out_byte !== want.data)
				note_miss("out_byte", {24'd0, out_byte}, {24'd0, want.data});
			if (byte_valid !== want.valid)
				note_miss("byte_valid", {31'd0, byte_valid}, {31'd0, want.valid});
			if (out_last !== want.fin)
				note_miss("out_last", {31'd0, out_last}, {31'd0, want.fin});
			if (status !== want.code)
				note_miss("status", {30'd0, status}, {30'd0, want.code});
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beats_due.delete();
			cfg_mode = MODE_APPEND;
			cfg_seed = '0;
			crc_acc = '0;
			for (int k = 0; k < 4; k++)
				delay_line[k] = '0;
			seen = '0;
			fail_count = 0;
			beats_left = 0;
		end else begin
			if (in_valid && !in_stall)
				predict_beats(data_byte, last);
			if (out_valid && !out_stall)
				check_beat();
			if (cfg_we) begin
				case (cfg_index)
					CFG_MODE:     cfg_mode = cfg_data[0];
					CFG_CRC_INIT: cfg_seed = cfg_data;
					default:      ;
				endcase
			end
			beats_left = beats_due.size();
		end
	end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// top of the crc32_trailer_append_check bench: clock, reset, config writes, byte stimulus,
// output stall pattern and the verdict; checking lives in crc32ta_stream_check
// depends on crc32ta_pkg, crc32_trailer_append_check, crc32ta_stream_check

module tb;
	import crc32ta_pkg::*;

	localparam int LIMIT    = 400000;  // cycle budget for the whole run
	localparam int TAIL     = 10;      // extra cycles after the last expected item
	localparam int HOLD_LEN = 60;      // long receiver hold-off

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [31:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  data_byte;
	logic        last;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  out_byte;
	logic        byte_valid;
	logic        out_last;
	logic [1:0]  status;

	int          fail_total;
	int          beats_left;

	// knobs shared between the stimulus and the receiver process
	int          tx_pct = 0;
	int          rx_pct = 0;
	bit          hold_pending = 1'b0;
	int          sent = 0;
	int          cycles = 0;

	// what the block was last told, needed to build good trailers
	logic        mode_now = MODE_APPEND;
	logic [31:0] seed_now = '0;

	crc32_trailer_append_check DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_byte  (data_byte),
		.last       (last),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.byte_valid (byte_valid),
		.out_last   (out_last),
		.status     (status)
	);

	crc32ta_stream_check u_stream_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_byte  (data_byte),
		.last       (last),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.byte_valid (byte_valid),
		.out_last   (out_last),
		.status     (status),
		.fail_count (fail_total),
		.beats_left (beats_left)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// trailer generator only, byte-wise crc over the payload
	function automatic logic [31:0] crc_next(input logic [31:0] c, input logic [7:0] d);
		c = c ^ {24'd0, d};
		repeat (8)
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		return c;
	endfunction

	// offer one item and hold it until accepted, then maybe leave a gap
	task automatic push_byte(input logic [7:0] d, input logic fin);
		int gap;
		in_valid <= 1'b1;
		data_byte <= d;
		last <= fin;
		do @(posedge clk); while (in_stall);
		sent++;
		gap = 0;
		while (gap < 40 && $urandom_range(0, 99) < tx_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// stop offering, wait until every expected item is out, then let the pipe empty
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (beats_left != 0)
			@(posedge clk);
		repeat (TAIL) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == CFG_MODE)
			mode_now = val[0];
		else
			seed_now = val;
	endtask

	task automatic reconfigure(input logic m, input logic [31:0] s);
		settle();
		write_reg(CFG_MODE, {31'd0, m});
		write_reg(CFG_CRC_INIT, s);
	endtask

	// in check mode a packet of four or more bytes ends in the crc of its payload,
	// optionally broken by one flipped bit anywhere in the packet
	task automatic send_packet(input int len, input bit good);
		logic [7:0]  pkt[$];
		logic [31:0] c;
		logic [7:0]  b;
		int          j;
		if (mode_now == MODE_CHECK && len >= 4) begin
			c = seed_now;
			for (int k = 0; k < len - 4; k++) begin
				b = $urandom_range(0, 255);
				pkt.push_back(b);
				c = crc_next(c, b);
			end
			for (int k = 0; k < 4; k++)
				pkt.push_back(c[8*k +: 8]);
			if (!good) begin
				j = $urandom_range(0, len - 1);
				pkt[j] = pkt[j] ^ (8'd1 << $urandom_range(0, 7));
			end
		end else begin
			for (int k = 0; k < len; k++)
				pkt.push_back($urandom_range(0, 255));
		end
		for (int k = 0; k < len; k++)
			push_byte(pkt[k], k == len - 1);
	endtask

	// receiver: random stalls, or a long hold-off when one is requested
	initial begin
		int hold_left;
		hold_left = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_pending) begin
				hold_pending = 1'b0;
				hold_left = HOLD_LEN;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(0, 99) < rx_pct);
			end
		end
	end

	// run budget, reckoned well above the slowest legal run
	initial begin
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("crc32_trailer_append_check: mismatch");
		$finish;
	end

	initial begin
		int          ph;
		int          seg;
		int          goal;
		int          len;
		int          r;
		logic        m;
		logic [31:0] s;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_MODE;
		cfg_data = '0;
		in_valid = 1'b0;
		data_byte = '0;
		last = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, light idling on both sides
		tx_pct = 20;
		rx_pct = 20;

		// append: single-byte packet of zero, seed zero
		write_reg(CFG_MODE, {31'd0, MODE_APPEND});
		write_reg(CFG_CRC_INIT, 32'd0);
		push_byte(8'h00, 1'b1);

		// append with all-ones seed, extreme bytes
		reconfigure(MODE_APPEND, 32'hFFFF_FFFF);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h80, 1'b0);
		push_byte(8'h01, 1'b1);

		// check: too short, trailer only (no payload leaves), good, mismatch
		reconfigure(MODE_CHECK, 32'd0);
		send_packet(3, 1'b1);
		send_packet(4, 1'b1);
		send_packet(5, 1'b1);
		send_packet(6, 1'b0);

		// mode flipped halfway through a check packet, finished in append
		push_byte(8'hA5, 1'b0);
		push_byte(8'h5A, 1'b0);
		settle();
		write_reg(CFG_MODE, {31'd0, MODE_APPEND});
		push_byte(8'hC3, 1'b1);

		// append packet finished in check mode over a stale delay line,
		// seed written mid-packet only counts from the next packet
		push_byte(8'h3C, 1'b0);
		settle();
		write_reg(CFG_MODE, {31'd0, MODE_CHECK});
		write_reg(CFG_CRC_INIT, 32'hFFFF_FFFF);
		push_byte(8'h7E, 1'b0);
		push_byte(8'h81, 1'b1);

		// random part: three idling patterns, four config settings each
		for (ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					tx_pct = 35;
					rx_pct = 86;
				end
				1: begin
					tx_pct = 86;
					rx_pct = 35;
				end
				default: begin
					tx_pct = 0;
					rx_pct = 0;
				end
			endcase
			for (seg = 0; seg < 4; seg++) begin
				// both modes in every phase, seed extremes first
				m = (seg < 2) ? logic'((seg + ph) % 2) : logic'($urandom_range(0, 1));
				case (seg)
					0: s = 32'hFFFF_FFFF;
					1: s = 32'd0;
					default: s = $urandom();
				endcase
				if (ph == 2 && seg == 0)
					m = MODE_APPEND;
				reconfigure(m, s);
				// receiver holds off while the sender keeps pushing, so the block backs up
				if (ph == 2 && seg == 0)
					hold_pending = 1'b1;
				goal = sent + 20;
				while (sent < goal) begin
					r = $urandom_range(0, 9);
					if (r < 7)
						len = $urandom_range(1, 8);
					else if (r < 9)
						len = $urandom_range(9, 20);
					else
						len = $urandom_range(1, 3);
					send_packet(len, $urandom_range(0, 9) < 7);
				end
			end
		end

		settle();
		if (fail_total == 0)
			$display("crc32_trailer_append_check: match");
		else
			$display("crc32_trailer_append_check: mismatch");
		$finish;
	end

endmodule
